// ----- src/srq_pkg.sv -----
// Shared types and constants for the strict-priority ready queue.
`default_nettype none

package srq_pkg;

    // Default sizes handed to the top-level parameters
    localparam int DEF_NUM_LEVELS  = 8;
    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_TAG_WIDTH   = 8;

    // Fixed port widths
    localparam int PRIO_W    = 3;
    localparam int PORT_TAG_W = 8;
    localparam int TAG_MAX_W = 16;

    // Operation codes on func
    localparam logic FUNC_ENQ = 1'b0;
    localparam logic FUNC_DEQ = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESP
    } srq_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // capture the incoming word
        logic exec;   // perform enqueue or dequeue
    } srq_cmd_t;

endpackage

`default_nettype wire

// ----- src/srq_ctrl.sv -----
// Sequencing state machine: accept, execute, respond.
`default_nettype none

module srq_ctrl
    import srq_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    output logic          done,
    output srq_cmd_t      cmd
);

    srq_state_t state_reg;
    srq_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy     = 1'b1;
        done     = 1'b0;
        cmd.load = 1'b0;
        cmd.exec = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            ST_RESP:
            begin
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- src/srq_ram.sv -----
// Entry store: one write port, one registered read port.
`default_nettype none

module srq_ram
    import srq_pkg::*;
#(
    parameter int DEPTH  = DEF_NUM_LEVELS * DEF_QUEUE_DEPTH,
    parameter int DATA_W = DEF_TAG_WIDTH,
    localparam int ADDR_W = $clog2(DEPTH)
)
(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- src/srq_dp.sv -----
// Datapath: per-level pointers and counts, level select, entry store.
`default_nettype none

module srq_dp
    import srq_pkg::*;
#(
    parameter int NUM_LEVELS  = DEF_NUM_LEVELS,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int TAG_WIDTH   = DEF_TAG_WIDTH
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire srq_cmd_t              cmd,
    input  wire logic                  func,
    input  wire logic [PRIO_W-1:0]     priority_req,
    input  wire logic [PORT_TAG_W-1:0] thread_tag,
    output logic                       found,
    output logic      [PORT_TAG_W-1:0] out_tag,
    output logic                       refused
);

    localparam int LVL_W  = $clog2(NUM_LEVELS);
    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRIES = NUM_LEVELS * QUEUE_DEPTH;
    localparam int ADDR_W = $clog2(ENTRIES);

    function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(QUEUE_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] addr_of(input logic [LVL_W-1:0] l,
                                                  input logic [PTR_W-1:0] p);
        logic [ADDR_W-1:0] base;
        base = ADDR_W'(ADDR_W'(l) * ADDR_W'(QUEUE_DEPTH));
        return base + ADDR_W'(p);
    endfunction

    // captured word
    logic                 op_reg;
    logic [PRIO_W-1:0]    lvl_reg;
    logic [TAG_WIDTH-1:0] tag_reg;

    logic [PTR_W-1:0] head_reg  [NUM_LEVELS];
    logic [PTR_W-1:0] head_next [NUM_LEVELS];
    logic [PTR_W-1:0] tail_reg  [NUM_LEVELS];
    logic [PTR_W-1:0] tail_next [NUM_LEVELS];
    logic [CNT_W-1:0] count_reg  [NUM_LEVELS];
    logic [CNT_W-1:0] count_next [NUM_LEVELS];

    logic found_reg, found_next;
    logic refused_reg, refused_next;

    logic [TAG_MAX_W-1:0] tag_wide;
    logic [TAG_MAX_W-1:0] rd_wide;
    logic [7:0]           lvl_ext;
    logic [LVL_W-1:0]     lvl_idx;
    logic                 lvl_ok;
    logic [LVL_W-1:0]     sel;
    logic                 any;

    logic                 we;
    logic                 re;
    logic [ADDR_W-1:0]    waddr;
    logic [ADDR_W-1:0]    raddr;
    logic [TAG_WIDTH-1:0] rdata;

    assign tag_wide = TAG_MAX_W'(thread_tag);
    assign lvl_ext  = 8'(lvl_reg);
    assign lvl_idx  = lvl_ext[LVL_W-1:0];
    assign lvl_ok   = int'(lvl_reg) < NUM_LEVELS;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= func;
            lvl_reg <= priority_req;
            tag_reg <= tag_wide[TAG_WIDTH-1:0];
        end
        found_reg   <= found_next;
        refused_reg <= refused_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // lowest-numbered non-empty level wins
    always_comb
    begin
        any = 1'b0;
        sel = '0;
        for (int i = NUM_LEVELS - 1; i >= 0; i--)
        begin
            if (count_reg[i] != '0)
            begin
                any = 1'b1;
                sel = LVL_W'(i);
            end
        end
    end

    assign waddr = addr_of(lvl_idx, tail_reg[lvl_idx]);
    assign raddr = addr_of(sel, head_reg[sel]);

    always_comb
    begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        found_next   = found_reg;
        refused_next = refused_reg;
        we           = 1'b0;
        re           = 1'b0;
        if (cmd.exec)
        begin
            if (op_reg == FUNC_ENQ)
            begin
                found_next = 1'b0;
                if (!lvl_ok)
                begin
                    refused_next = 1'b1;
                end
                else if (count_reg[lvl_idx] == CNT_W'(QUEUE_DEPTH))
                begin
                    refused_next = 1'b1;
                end
                else
                begin
                    refused_next        = 1'b0;
                    we                  = 1'b1;
                    tail_next[lvl_idx]  = adv(tail_reg[lvl_idx]);
                    count_next[lvl_idx] = count_reg[lvl_idx] + CNT_W'(1);
                end
            end
            else
            begin
                refused_next = 1'b0;
                found_next   = any;
                if (any)
                begin
                    re              = 1'b1;
                    head_next[sel]  = adv(head_reg[sel]);
                    count_next[sel] = count_reg[sel] - CNT_W'(1);
                end
            end
        end
    end

    srq_ram #(
        .DEPTH  (ENTRIES),
        .DATA_W (TAG_WIDTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (tag_reg),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rd_wide = TAG_MAX_W'(rdata);
    assign found   = found_reg;
    assign refused = refused_reg;
    assign out_tag = found_reg ? rd_wide[PORT_TAG_W-1:0] : '0;

endmodule

`default_nettype wire

// ----- src/strict_priority_ready_queue_top.sv -----
// Top level of the strict-priority ready queue.
//
//  Channel   Handshake            Word
//  --------  -------------------  -------------------------------------
//  request   start / busy         func, priority_req, thread_tag
//  result    done (one cycle)     found, out_tag, refused
//
//  Each word passes through capture on the accepting edge, the execute
//  state, in which the datapath updates the level pointers and counts and
//  issues the entry store access, and the response state, in which done
//  shows the result (read data from the store's registered read port).
//  busy stays high from the accepting edge until done has been shown.
//  Reset (rst_n low, asynchronous) empties every level; the entry store
//  itself is not cleared, so no clearing pass is needed.
//  The receiver cannot hold results off: done lasts exactly one cycle.
`default_nettype none

module strict_priority_ready_queue_top
    import srq_pkg::*;
#(
    parameter int NUM_LEVELS  = DEF_NUM_LEVELS,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int TAG_WIDTH   = DEF_TAG_WIDTH
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic                  func,
    input  wire logic [PRIO_W-1:0]     priority_req,
    input  wire logic [PORT_TAG_W-1:0] thread_tag,
    output logic                       done,
    output logic                       found,
    output logic      [PORT_TAG_W-1:0] out_tag,
    output logic                       refused
);

    // commands from the sequencer into the datapath
    srq_cmd_t cmd;

    srq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    // pointers, counts, level select and the entry store
    srq_dp #(
        .NUM_LEVELS  (NUM_LEVELS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TAG_WIDTH   (TAG_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .func         (func),
        .priority_req (priority_req),
        .thread_tag   (thread_tag),
        .found        (found),
        .out_tag      (out_tag),
        .refused      (refused)
    );

endmodule

`default_nettype wire

// ----- src/srq_checker.sv -----
// Port-level checks for the ready queue, bound to the top level.
`default_nettype none

module srq_checker
    import srq_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  start,
    input wire logic                  busy,
    input wire logic                  done,
    input wire logic                  found,
    input wire logic [PORT_TAG_W-1:0] out_tag,
    input wire logic                  refused
);

    // an accepted word makes the block busy on the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accept");

    // the result is shown in the response state, which follows the execute state after the accepting edge
    a_resp_time: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> ##1 done)
        else $error("result not delivered on time");

    // a result is shown only while the word is still in flight
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done while idle");

    // a word is never both a dequeue hit and a refused enqueue
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(found && refused))
        else $error("found and refused together");

    // no entry returned means a zero tag
    a_zero_tag: assert property (@(posedge clk) disable iff (!rst_n)
        done && !found |-> out_tag == '0)
        else $error("nonzero tag without an entry");

endmodule

bind strict_priority_ready_queue_top srq_checker u_srq_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .done    (done),
    .found   (found),
    .out_tag (out_tag),
    .refused (refused)
);

`default_nettype wire
